// ===== hdl/sorted_array_insert_remove_core_macros.svh =====
// Assertion helpers for the sorted list core.
`ifndef SORTED_ARRAY_INSERT_REMOVE_CORE_MACROS_SVH
`define SORTED_ARRAY_INSERT_REMOVE_CORE_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define SAI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted list assertion failed");

// Condition in one cycle implies an outcome in the next.
`define SAI_ASSERT_NEXT(lbl, cond, outcome) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (outcome)) \
    else $error("sorted list assertion failed");

`endif

// ===== hdl/sai_pkg.sv =====
package sai_pkg;

  localparam int unsigned DEPTH_DEF     = 16;
  localparam int unsigned KEY_WIDTH_DEF = 32;
  localparam int unsigned KEY_IO_W      = 32;
  localparam int unsigned POS_W         = 4;
  localparam int unsigned CNT_W         = 5;
  localparam int unsigned CAP_W         = 5;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADPOS = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORDER    = 1'd0,
    REG_CAPACITY = 1'd1
  } cfg_reg_e;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic             cmp;
    logic             ins;
    logic             rem;
    logic             desc;
    logic [POS_W-1:0] pos;
  } ctl_t;

endpackage

// ===== hdl/sai_cell.sv =====
module sai_cell import sai_pkg::*; #(
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int unsigned IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctl_t                 ctl_i,
  input  logic [KEY_WIDTH-1:0] new_key_i,
  input  logic                 occ_i,
  input  logic [KEY_WIDTH-1:0] left_key_i,
  input  logic [KEY_WIDTH-1:0] right_key_i,
  input  logic                 pass_i,
  output logic                 pass_o,
  output logic [KEY_WIDTH-1:0] key_o
);

  logic [KEY_WIDTH-1:0] key_q;
  logic                 before_q;
  logic                 ob;
  logic                 at_or_after;

  assign ob = ctl_i.desc ? (key_q > new_key_i) : (key_q < new_key_i);

  if (IDX >= (1 << POS_W)) begin : g_far
    assign at_or_after = 1'b1;
  end else begin : g_near
    assign at_or_after = ctl_i.pos <= POS_W'(IDX);
  end

  // Stays high while every cell up to here orders before the new key.
  assign pass_o = pass_i & before_q;
  assign key_o  = key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      before_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      before_q <= occ_i & ob;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      if (!pass_i) begin
        key_q <= left_key_i;
      end else if (!before_q) begin
        key_q <= new_key_i;
      end
    end else if (ctl_i.rem && at_or_after) begin
      key_q <= right_key_i;
    end
  end

endmodule

// ===== hdl/sorted_array_insert_remove_core.sv =====
// Sorted key list built as a chain of compare-and-shift cells.
// Input channel (in_valid_i/in_ready_o) carries opcode_i, key_in_i, position_i:
// insert a key, read the key at a position, or remove the key at a position.
// Output channel (out_valid_o/out_ready_i) returns key_out_o, status_o and
// count_o, one result per input transfer, in order.
// Config channel (cfg_valid_i/cfg_ready_o) writes order_descending (index 0)
// and capacity (index 1); it is always ready.
// Each item passes through a compare state and then an execute state. The
// compare state registers each cell's compare against the new key; the execute
// state resolves the insertion point along the chain and shifts all cells at
// once.
// The result sits in an output register; the next item is taken and compared
// while it waits. If the receiver stalls, the second item holds in its execute
// state until the output register frees, and no further item is taken.
// Reset empties the list (count 0), sets ascending order and capacity 16.
// Stored keys are not cleared; only positions below the count are visible.
`include "sorted_array_insert_remove_core_macros.svh"

module sorted_array_insert_remove_core import sai_pkg::*; #(
  parameter int unsigned DEPTH     = DEPTH_DEF,
  parameter int unsigned KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            opcode_i,
  input  logic [KEY_IO_W-1:0]   key_in_i,
  input  logic [POS_W-1:0]      position_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KEY_IO_W-1:0]   key_out_o,
  output logic [1:0]            status_o,
  output logic [CNT_W-1:0]      count_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned FW   = $clog2(DEPTH + 1);
  localparam int unsigned CMPW = (FW > CAP_W) ? FW : CAP_W;
  localparam int unsigned RD   = (DEPTH < (1 << POS_W)) ? DEPTH : (1 << POS_W);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [POS_W-1:0]     pos_q;
  logic [FW-1:0]        fill_q, fill_d;
  logic                 desc_q;
  logic [CAP_W-1:0]     cap_q;
  logic                 out_valid_q;
  logic [KEY_IO_W-1:0]  key_out_q, key_out_d;
  status_e              status_q, status_d;
  logic [CNT_W-1:0]     count_q;

  logic                 in_xfer, commit, full, pos_bad, ins_ok, rem_ok;
  logic [KEY_WIDTH-1:0] read_key;
  logic [DEPTH-1:0]     occ;
  logic [DEPTH:0]       pass;
  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  ctl_t                 ctl;

  assign commit     = (state_q == S_EXEC) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE) || commit;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign full    = (CMPW'(fill_q) >= CMPW'(cap_q)) || (fill_q >= FW'(DEPTH));
  assign pos_bad = CMPW'(pos_q) >= CMPW'(fill_q);
  assign ins_ok  = (op_q == OP_INSERT) && !full;
  assign rem_ok  = (op_q == OP_REMOVE) && !pos_bad;

  assign ctl.cmp  = (state_q == S_CMP);
  assign ctl.ins  = commit && ins_ok;
  assign ctl.rem  = commit && rem_ok;
  assign ctl.desc = desc_q;
  assign ctl.pos  = pos_q;

  assign pass[0] = 1'b1;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = FW'(i) < fill_q;
    sai_cell #(
      .KEY_WIDTH (KEY_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .new_key_i   (key_q),
      .occ_i       (occ[i]),
      .left_key_i  ((i == 0) ? key_q : cell_key[(i == 0) ? 0 : i - 1]),
      .right_key_i (cell_key[(i == DEPTH - 1) ? i : i + 1]),
      .pass_i      (pass[i]),
      .pass_o      (pass[i+1]),
      .key_o       (cell_key[i])
    );
  end

  always_comb begin
    read_key = '0;
    for (int i = 0; i < RD; i++) begin
      if (pos_q == POS_W'(i)) begin
        read_key = cell_key[i];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_xfer) state_d = S_CMP;
      S_CMP:  state_d = S_EXEC;
      S_EXEC: begin
        if (commit) begin
          state_d = in_xfer ? S_CMP : S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    fill_d    = fill_q;
    key_out_d = '0;
    status_d  = ST_OK;
    case (op_q)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          fill_d = fill_q + 1'b1;
        end
      end
      OP_READ: begin
        if (pos_bad) begin
          status_d = ST_BADPOS;
        end else begin
          key_out_d = KEY_IO_W'(read_key);
        end
      end
      OP_REMOVE: begin
        if (pos_bad) begin
          status_d = ST_BADPOS;
        end else begin
          fill_d = fill_q - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      desc_q      <= 1'b0;
      cap_q       <= CAP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        fill_q <= fill_d;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ORDER:    desc_q <= cfg_data_i[0];
          REG_CAPACITY: cap_q  <= CAP_W'(cfg_data_i);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q  <= op_e'(opcode_i);
      key_q <= KEY_WIDTH'(key_in_i);
      pos_q <= position_i;
    end
    if (commit) begin
      key_out_q <= key_out_d;
      status_q  <= status_d;
      count_q   <= CNT_W'(fill_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_out_o   = key_out_q;
  assign status_o    = status_q;
  assign count_o     = count_q;

  `SAI_ASSERT(a_state_onehot, $onehot(state_q))
  `SAI_ASSERT(a_fill_bound, fill_q <= FW'(DEPTH))
  `SAI_ASSERT_NEXT(a_take_starts_cmp, in_xfer, state_q == S_CMP)
  `SAI_ASSERT_NEXT(a_ins_grows, commit && ins_ok, fill_q == $past(fill_q) + 1'b1)
  `SAI_ASSERT_NEXT(a_full_holds, commit && (op_q == OP_INSERT) && full,
                   (fill_q == $past(fill_q)) && (status_q == ST_FULL))

endmodule

// ===== bench/sorted_array_insert_remove_core_tb.sv =====
module sorted_array_insert_remove_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sai_pkg::*;

  localparam int unsigned LIST_DEPTH  = DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [1:0]  OPC_SPARE   = 2'd3;

  typedef struct packed {
    logic [1:0]          opc;
    logic [KEY_IO_W-1:0] key;
    logic [POS_W-1:0]    pos;
  } list_op_t;

  typedef struct packed {
    logic [KEY_IO_W-1:0] key;
    logic [1:0]          status;
    logic [CNT_W-1:0]    count;
  } list_reply_t;

  logic                  clk_i = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            opcode = '0;
  logic [KEY_IO_W-1:0]   key_in = '0;
  logic [POS_W-1:0]      position = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [KEY_IO_W-1:0]   key_out;
  logic [1:0]            status;
  logic [CNT_W-1:0]      count;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sorted_array_insert_remove_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .opcode_i    (opcode),
    .key_in_i    (key_in),
    .position_i  (position),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .key_out_o   (key_out),
    .status_o    (status),
    .count_o     (count),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the list and its registers
  logic [KEY_IO_W-1:0] sorted_keys [LIST_DEPTH];
  int unsigned         list_fill = 0;
  logic                desc_mode = 1'b0;
  logic [CAP_W-1:0]    cap_reg = CAP_RESET;

  list_op_t    pending_ops [$];
  list_reply_t exp_replies [$];
  list_op_t    cur_op = '0;

  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int unsigned ops_taken = 0;
  int unsigned replies_seen = 0;
  int unsigned n_insert = 0, n_full = 0, n_read = 0, n_remove = 0, n_badpos = 0;
  int unsigned n_spare = 0, reg_writes = 0, peak_fill = 0;
  int unsigned send_gap = 0, recv_gap = 0, hold_left = 0, holds_done = 0;
  int unsigned next_hold_at = 300;

  function automatic list_reply_t predict_list_op(list_op_t op);
    list_reply_t r;
    int unsigned lim;
    int unsigned at;
    r = '0;
    lim = (cap_reg > LIST_DEPTH) ? LIST_DEPTH : cap_reg;
    case (op.opc)
      OP_INSERT: begin
        n_insert++;
        if (list_fill >= lim) begin
          r.status = ST_FULL;
          n_full++;
        end else begin
          at = 0;
          while (at < list_fill && (desc_mode ? (sorted_keys[at] > op.key)
                                              : (sorted_keys[at] < op.key)))
            at++;
          for (int i = list_fill; i > at; i--) sorted_keys[i] = sorted_keys[i-1];
          sorted_keys[at] = op.key;
          list_fill++;
          if (list_fill > peak_fill) peak_fill = list_fill;
        end
      end
      OP_READ: begin
        n_read++;
        if (op.pos >= list_fill) begin
          r.status = ST_BADPOS;
          n_badpos++;
        end else begin
          r.key = sorted_keys[op.pos];
        end
      end
      OP_REMOVE: begin
        n_remove++;
        if (op.pos >= list_fill) begin
          r.status = ST_BADPOS;
          n_badpos++;
        end else begin
          list_fill--;
          for (int i = op.pos; i < list_fill; i++) sorted_keys[i] = sorted_keys[i+1];
        end
      end
      default: n_spare++;
    endcase
    r.count = list_fill[CNT_W-1:0];
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sender
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        exp_replies.push_back(predict_list_op(cur_op));
        ops_taken++;
        send_gap = ((ops_taken / 64) % 4 == 1) ? 0 : pick_gap();
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          cur_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          opcode <= cur_op.opc;
          key_in <= cur_op.key;
          position <= cur_op.pos;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk_i) begin : recv_proc
    list_reply_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (exp_replies.size() == 0) begin
          $error("result transfer with nothing expected: key_out %h status %0d count %0d",
                 key_out, status, count);
          err_count++;
        end else begin
          want = exp_replies.pop_front();
          if (key_out !== want.key) begin
            $error("key_out mismatch: expected %h, got %h", want.key, key_out);
            err_count++;
          end
          if (status !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status);
            err_count++;
          end
          if (count !== want.count) begin
            $error("count mismatch: expected %0d, got %0d", want.count, count);
            err_count++;
          end
        end
        recv_gap = ((replies_seen / 50) % 4 == 2) ? 0 : pick_gap();
      end
      if (holds_done < 2 && replies_seen >= next_hold_at && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
        next_hold_at += 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sampled on the falling edge, after the sender has settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid || exp_replies.size() != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ORDER) desc_mode = data[0];
    else cap_reg = data;
    reg_writes++;
  endtask

  task automatic push_op(input logic [1:0] opc, input logic [KEY_IO_W-1:0] key,
                         input logic [POS_W-1:0] pos);
    list_op_t op;
    op.opc = opc;
    op.key = key;
    op.pos = pos;
    pending_ops.push_back(op);
  endtask

  function automatic list_op_t rand_op(bit grow);
    list_op_t op;
    int unsigned r;
    int unsigned kr;
    r = $urandom_range(0, 99);
    if (grow) op.opc = (r < 65) ? OP_INSERT : (r < 85) ? OP_READ : OP_REMOVE;
    else      op.opc = (r < 15) ? OP_INSERT : (r < 40) ? OP_READ : OP_REMOVE;
    kr = $urandom_range(0, 9);
    if (kr < 3)       op.key = $urandom_range(0, 7);
    else if (kr == 3) op.key = 32'hFFFF_FFFF - $urandom_range(0, 3);
    else              op.key = $urandom();
    op.pos = ($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, 15))
                                         : POS_W'($urandom_range(0, 3));
    return op;
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // empty list, extreme and equal keys, reads and removes at both ends
    push_op(OP_READ, '0, 4'd0);
    push_op(OP_REMOVE, '0, 4'd15);
    push_op(OP_INSERT, 32'h0000_0000, 4'd0);
    push_op(OP_INSERT, 32'hFFFF_FFFF, 4'd15);
    push_op(OP_INSERT, 32'h8000_0000, 4'd0);
    push_op(OP_INSERT, 32'h8000_0000, 4'd9);
    push_op(OP_INSERT, 32'h0000_0001, 4'd0);
    push_op(OP_READ, '0, 4'd0);
    push_op(OP_READ, '0, 4'd2);
    push_op(OP_READ, '0, 4'd4);
    push_op(OP_READ, 32'hFFFF_FFFF, 4'd5);
    push_op(OP_REMOVE, '0, 4'd4);
    push_op(OP_REMOVE, '0, 4'd0);
    push_op(OPC_SPARE, 32'hA5A5_5A5A, 4'd1);

    // capacity below the current fill
    write_reg(REG_CAPACITY, 5'd2);
    push_op(OP_INSERT, 32'h0000_1234, 4'd0);
    push_op(OP_READ, '0, 4'd2);
    push_op(OP_REMOVE, '0, 4'd0);
    push_op(OP_REMOVE, '0, 4'd0);
    push_op(OP_INSERT, 32'h0000_0005, 4'd0);
    push_op(OP_INSERT, 32'h0000_0006, 4'd0);

    // order flipped with keys held, zero and oversize capacity
    write_reg(REG_ORDER, 5'd1);
    write_reg(REG_CAPACITY, 5'd0);
    push_op(OP_INSERT, 32'h0000_0009, 4'd0);
    write_reg(REG_CAPACITY, 5'd31);
    push_op(OP_INSERT, 32'h0000_0003, 4'd0);
    push_op(OP_READ, '0, 4'd0);
    push_op(OP_READ, '0, 4'd1);
    push_op(OP_READ, '0, 4'd2);

    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0) begin
        write_reg(REG_ORDER, 5'd0);
        write_reg(REG_CAPACITY, 5'd16);
      end else if (p == 1) begin
        write_reg(REG_ORDER, 5'd1);
        write_reg(REG_CAPACITY, 5'd1);
      end else begin
        write_reg(REG_ORDER, CFG_DATA_W'($urandom_range(0, 1)));
        write_reg(REG_CAPACITY, ($urandom_range(0, 2) == 0) ? 5'd16
                                 : CFG_DATA_W'($urandom_range(2, 15)));
      end
      for (int i = 0; i < PHASE_ITEMS; i++)
        pending_ops.push_back(rand_op(((i / 40) % 2) == 0));
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("Covered %0d inserts (%0d refused full), %0d reads, %0d removes, %0d spare ops",
             n_insert, n_full, n_read, n_remove, n_spare);
    $display("  %0d bad positions, %0d register writes, list depth reached %0d",
             n_badpos, reg_writes, peak_fill);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
